>>> rtl/core/nsve_pkg.sv
package nsve_pkg;

    localparam int MAX_SENTENCE = 128;
    localparam int MAX_FIELDS   = 32;

    localparam int CFG_COUNT    = 5;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_METEO   = 3'd4;

    localparam logic [CFG_W-1:0] CFG_TEMP_RST    = 5'd1;
    localparam logic [CFG_W-1:0] CFG_DEPTH_RST   = 5'd2;
    localparam logic [CFG_W-1:0] CFG_SPEED_A_RST = 5'd5;
    localparam logic [CFG_W-1:0] CFG_SPEED_B_RST = 5'd7;
    localparam logic [CFG_W-1:0] CFG_METEO_RST   = 5'd7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [39:0] ID_MTW = 40'h47504D5457;
    localparam logic [39:0] ID_DPT = 40'h4750445054;
    localparam logic [39:0] ID_VHW = 40'h4750564857;
    localparam logic [39:0] ID_MDA = 40'h47504D4441;

    localparam logic [1:0] ST_PARSED  = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_NO_LF   = 2'd3;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_TEMP  = 3'd1;
    localparam logic [2:0] KIND_DEPTH = 3'd2;
    localparam logic [2:0] KIND_SPEED = 3'd3;
    localparam logic [2:0] KIND_METEO = 3'd4;

    // Largest magnitude kept by the number accumulator (2^31).
    localparam logic [31:0] MAG_SAT = 32'h8000_0000;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_LF
    } phase_t;

    typedef enum logic [2:0] {
        NP_START,
        NP_SIGNED,
        NP_INT,
        NP_FRAC,
        NP_DONE
    } nphase_t;

    typedef struct packed {
        logic [CFG_W-1:0] temp_field;
        logic [CFG_W-1:0] depth_field;
        logic [CFG_W-1:0] speed_field_a;
        logic [CFG_W-1:0] speed_field_b;
        logic [CFG_W-1:0] meteo_field;
    } cfg_t;

    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] ch;
    } num_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [31:0] value_a;
        logic [31:0] value_b;
    } result_t;

endpackage

>>> rtl/core/nsve_num.sv
module nsve_num
(
    input  logic                clk,
    input  logic                rst_n,
    input  nsve_pkg::num_cmd_t  cmd,
    output logic [31:0]         value
);

    nsve_pkg::nphase_t nphase_reg, nphase_next;
    logic [31:0] mag_reg, mag_next;
    logic [1:0]  frac_reg, frac_next;
    logic        neg_reg, neg_next;
    logic        rnd_reg, rnd_next;

    logic        is_digit;
    logic        is_blank;
    logic [3:0]  dval;
    logic [35:0] int_sum;
    logic [32:0] frac_sum;
    logic [31:0] int_mag;
    logic [31:0] frac_mag;
    logic [32:0] rounded;
    logic [31:0] neg_mag;

    assign is_digit = (cmd.ch >= nsve_pkg::CH_ZERO) && (cmd.ch <= nsve_pkg::CH_NINE);
    assign is_blank = (cmd.ch == nsve_pkg::CH_SPACE)
                   || ((cmd.ch >= nsve_pkg::CH_TAB) && (cmd.ch <= nsve_pkg::CH_FF));
    assign dval     = cmd.ch[3:0];

    // mag * 10 + 100 * digit, done as shifts and adds.
    assign int_sum  = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                    + {26'd0, dval, 6'd0} + {27'd0, dval, 5'd0}
                    + {30'd0, dval, 2'b00};
    assign int_mag  = (int_sum > {4'd0, nsve_pkg::MAG_SAT}) ? nsve_pkg::MAG_SAT
                                                             : int_sum[31:0];

    always_comb
    begin
        frac_sum = {1'b0, mag_reg};
        case (frac_reg)
            2'd0:    frac_sum = {1'b0, mag_reg} + {28'd0, dval, 1'b0} + {26'd0, dval, 3'b000};
            2'd1:    frac_sum = {1'b0, mag_reg} + {29'd0, dval};
            default: frac_sum = {1'b0, mag_reg};
        endcase
    end

    assign frac_mag = (frac_sum > {1'b0, nsve_pkg::MAG_SAT}) ? nsve_pkg::MAG_SAT
                                                              : frac_sum[31:0];

    always_comb
    begin
        nphase_next = nphase_reg;
        mag_next    = mag_reg;
        frac_next   = frac_reg;
        neg_next    = neg_reg;
        rnd_next    = rnd_reg;
        if (cmd.clear)
        begin
            nphase_next = nsve_pkg::NP_START;
            mag_next    = '0;
            frac_next   = '0;
            neg_next    = 1'b0;
            rnd_next    = 1'b0;
        end
        else if (cmd.feed)
        begin
            case (nphase_reg)
                nsve_pkg::NP_START, nsve_pkg::NP_SIGNED, nsve_pkg::NP_INT:
                begin
                    if ((nphase_reg == nsve_pkg::NP_START) && is_blank)
                    begin
                        nphase_next = nphase_reg;
                    end
                    else if ((nphase_reg == nsve_pkg::NP_START)
                             && ((cmd.ch == nsve_pkg::CH_PLUS)
                                 || (cmd.ch == nsve_pkg::CH_MINUS)))
                    begin
                        neg_next    = (cmd.ch == nsve_pkg::CH_MINUS);
                        nphase_next = nsve_pkg::NP_SIGNED;
                    end
                    else if (is_digit)
                    begin
                        mag_next    = int_mag;
                        nphase_next = nsve_pkg::NP_INT;
                    end
                    else if (cmd.ch == nsve_pkg::CH_DOT)
                    begin
                        nphase_next = nsve_pkg::NP_FRAC;
                    end
                    else
                    begin
                        nphase_next = nsve_pkg::NP_DONE;
                    end
                end
                nsve_pkg::NP_FRAC:
                begin
                    if (!is_digit)
                    begin
                        nphase_next = nsve_pkg::NP_DONE;
                    end
                    else
                    begin
                        mag_next = frac_mag;
                        if (frac_reg == 2'd2)
                        begin
                            rnd_next = (dval >= 4'd5);
                        end
                        if (frac_reg != 2'd3)
                        begin
                            frac_next = frac_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    nphase_next = nphase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nphase_reg <= nsve_pkg::NP_START;
            mag_reg    <= '0;
            frac_reg   <= '0;
            neg_reg    <= 1'b0;
            rnd_reg    <= 1'b0;
        end
        else
        begin
            nphase_reg <= nphase_next;
            mag_reg    <= mag_next;
            frac_reg   <= frac_next;
            neg_reg    <= neg_next;
            rnd_reg    <= rnd_next;
        end
    end

    // Rounded magnitude, then clamped to the signed 32-bit range.
    assign rounded = {1'b0, mag_reg} + {32'd0, rnd_reg};
    assign neg_mag = (rounded > {1'b0, nsve_pkg::MAG_SAT}) ? nsve_pkg::MAG_SAT
                                                            : rounded[31:0];

    always_comb
    begin
        if (neg_reg)
        begin
            value = 32'd0 - neg_mag;
        end
        else if (rounded > {1'b0, nsve_pkg::MAG_SAT - 32'd1})
        begin
            value = nsve_pkg::MAG_SAT - 32'd1;
        end
        else
        begin
            value = rounded[31:0];
        end
    end

endmodule

>>> rtl/core/nsve_ctl.sv
module nsve_ctl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         ch,
    input  nsve_pkg::cfg_t     cfg,
    output logic               emit,
    output nsve_pkg::result_t  result
);

    nsve_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [4:0]  fidx_reg, fidx_next;
    logic [39:0] id_reg, id_next;
    logic [2:0]  kind_reg, kind_next;
    logic        beyond_reg, beyond_next;
    logic [31:0] acc_a_reg, acc_a_next;
    logic [31:0] acc_b_reg, acc_b_next;

    nsve_pkg::num_cmd_t num_cmd;
    logic [31:0] num_value;

    logic [2:0]  id_kind;
    logic [4:0]  tgt_a;
    logic [4:0]  tgt_b;
    logic [2:0]  end_kind;
    logic [31:0] end_acc_a;
    logic [31:0] end_acc_b;
    logic        overrun;

    nsve_num u_num
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (num_cmd),
        .value (num_value)
    );

    always_comb
    begin
        case (id_reg)
            nsve_pkg::ID_MTW: id_kind = nsve_pkg::KIND_TEMP;
            nsve_pkg::ID_DPT: id_kind = nsve_pkg::KIND_DEPTH;
            nsve_pkg::ID_VHW: id_kind = nsve_pkg::KIND_SPEED;
            nsve_pkg::ID_MDA: id_kind = nsve_pkg::KIND_METEO;
            default:          id_kind = nsve_pkg::KIND_NONE;
        endcase
    end

    always_comb
    begin
        tgt_a = '0;
        tgt_b = '0;
        case (kind_reg)
            nsve_pkg::KIND_TEMP:  tgt_a = cfg.temp_field;
            nsve_pkg::KIND_DEPTH: tgt_a = cfg.depth_field;
            nsve_pkg::KIND_SPEED:
            begin
                tgt_a = cfg.speed_field_a;
                tgt_b = cfg.speed_field_b;
            end
            nsve_pkg::KIND_METEO: tgt_a = cfg.meteo_field;
            default:
            begin
                tgt_a = '0;
                tgt_b = '0;
            end
        endcase
    end

    // Effect of closing the current field. The id field sets the kind, and a
    // value field lands in an accumulator when its number matches a target.
    always_comb
    begin
        end_kind  = kind_reg;
        end_acc_a = acc_a_reg;
        end_acc_b = acc_b_reg;
        if (!beyond_reg)
        begin
            if (fidx_reg == 5'd0)
            begin
                end_kind = (count_reg == 8'd6) ? id_kind : nsve_pkg::KIND_NONE;
            end
            else
            begin
                if ((tgt_a != 5'd0) && (fidx_reg == tgt_a))
                begin
                    end_acc_a = num_value;
                end
                if ((tgt_b != 5'd0) && (fidx_reg == tgt_b))
                begin
                    end_acc_b = num_value;
                end
            end
        end
    end

    assign overrun = ({1'b0, count_reg} + 9'd1) > 9'(nsve_pkg::MAX_SENTENCE);

    always_comb
    begin
        emit = 1'b0;
        case (phase_reg)
            nsve_pkg::PH_LF:   emit = 1'b1;
            nsve_pkg::PH_BODY: emit = (ch != nsve_pkg::CH_CR) && overrun;
            default:           emit = 1'b0;
        endcase
    end

    always_comb
    begin
        result = '0;
        if (phase_reg == nsve_pkg::PH_BODY)
        begin
            result.status = nsve_pkg::ST_OVERRUN;
        end
        else if (ch != nsve_pkg::CH_LF)
        begin
            result.status = nsve_pkg::ST_NO_LF;
        end
        else if (kind_reg == nsve_pkg::KIND_NONE)
        begin
            result.status = nsve_pkg::ST_UNKNOWN;
        end
        else
        begin
            result.status  = nsve_pkg::ST_PARSED;
            result.kind    = kind_reg;
            result.value_a = acc_a_reg;
            result.value_b = (kind_reg == nsve_pkg::KIND_SPEED) ? acc_b_reg : 32'd0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        fidx_next   = fidx_reg;
        id_next     = id_reg;
        kind_next   = kind_reg;
        beyond_next = beyond_reg;
        acc_a_next  = acc_a_reg;
        acc_b_next  = acc_b_reg;
        num_cmd     = '0;
        num_cmd.ch  = ch;
        case (phase_reg)
            nsve_pkg::PH_HUNT:
            begin
                if (ch == nsve_pkg::CH_DOLLAR)
                begin
                    phase_next    = nsve_pkg::PH_BODY;
                    count_next    = 8'd1;
                    fidx_next     = '0;
                    id_next       = '0;
                    kind_next     = nsve_pkg::KIND_NONE;
                    beyond_next   = 1'b0;
                    acc_a_next    = '0;
                    acc_b_next    = '0;
                    num_cmd.clear = 1'b1;
                end
            end
            nsve_pkg::PH_LF:
            begin
                phase_next = nsve_pkg::PH_HUNT;
                count_next = '0;
            end
            nsve_pkg::PH_BODY:
            begin
                if (ch == nsve_pkg::CH_CR)
                begin
                    kind_next  = end_kind;
                    acc_a_next = end_acc_a;
                    acc_b_next = end_acc_b;
                    phase_next = nsve_pkg::PH_LF;
                end
                else if (overrun)
                begin
                    phase_next = nsve_pkg::PH_HUNT;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                    if (ch == nsve_pkg::CH_COMMA)
                    begin
                        kind_next  = end_kind;
                        acc_a_next = end_acc_a;
                        acc_b_next = end_acc_b;
                        if (fidx_reg >= 5'(nsve_pkg::MAX_FIELDS - 1))
                        begin
                            beyond_next = 1'b1;
                        end
                        else
                        begin
                            fidx_next = fidx_reg + 5'd1;
                        end
                        num_cmd.clear = 1'b1;
                    end
                    else if (fidx_reg == 5'd0)
                    begin
                        id_next = {id_reg[31:0], ch};
                    end
                    else if (!beyond_reg)
                    begin
                        num_cmd.feed = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = nsve_pkg::PH_HUNT;
            end
        endcase
        if (!step)
        begin
            num_cmd.clear = 1'b0;
            num_cmd.feed  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= nsve_pkg::PH_HUNT;
            count_reg  <= '0;
            fidx_reg   <= '0;
            id_reg     <= '0;
            kind_reg   <= nsve_pkg::KIND_NONE;
            beyond_reg <= 1'b0;
            acc_a_reg  <= '0;
            acc_b_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            fidx_reg   <= fidx_next;
            id_reg     <= id_next;
            kind_reg   <= kind_next;
            beyond_reg <= beyond_next;
            acc_a_reg  <= acc_a_next;
            acc_b_reg  <= acc_b_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 8'(nsve_pkg::MAX_SENTENCE))
        else $error("sentence byte count exceeds its limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == nsve_pkg::PH_HUNT) |-> (count_reg == 8'd0))
        else $error("byte count not cleared while hunting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == nsve_pkg::PH_BODY) |-> (count_reg != 8'd0))
        else $error("sentence body with zero byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (phase_reg == nsve_pkg::PH_HUNT))
        else $error("no return to hunting after a result");

endmodule

>>> rtl/core/nmea_sentence_value_extractor_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------
// in       | in_valid / in_stall  | rx_byte
// out      | out_valid / out_stall| status, kind, value_a, value_b
// cfg      | cfg_we (write only)  | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; each byte is held in an
// input register while the sentence state and the decimal accumulator
// update from it. A result is loaded into the output register at the edge
// where its byte leaves the input register.
// Reset (rst_n low, asynchronous) returns to hunting for '$' and loads the
// default field positions.
// While out_stall holds a result, bytes that produce no result still flow;
// a byte that would produce a result waits in the input register.
module nmea_sentence_value_extractor_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [2:0]                          kind,
    output logic signed [31:0]                  value_a,
    output logic signed [31:0]                  value_b,
    input  logic                                cfg_we,
    input  logic [nsve_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nsve_pkg::CFG_W-1:0]          cfg_data
);

    nsve_pkg::cfg_t    cfg_reg;
    nsve_pkg::result_t res_reg;
    nsve_pkg::result_t ctl_result;

    logic       in_full_reg, in_full_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       ctl_emit;
    logic       advance;
    logic       in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_field    <= nsve_pkg::CFG_TEMP_RST;
            cfg_reg.depth_field   <= nsve_pkg::CFG_DEPTH_RST;
            cfg_reg.speed_field_a <= nsve_pkg::CFG_SPEED_A_RST;
            cfg_reg.speed_field_b <= nsve_pkg::CFG_SPEED_B_RST;
            cfg_reg.meteo_field   <= nsve_pkg::CFG_METEO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nsve_pkg::CFG_TEMP:    cfg_reg.temp_field    <= cfg_data;
                nsve_pkg::CFG_DEPTH:   cfg_reg.depth_field   <= cfg_data;
                nsve_pkg::CFG_SPEED_A: cfg_reg.speed_field_a <= cfg_data;
                nsve_pkg::CFG_SPEED_B: cfg_reg.speed_field_b <= cfg_data;
                nsve_pkg::CFG_METEO:   cfg_reg.meteo_field   <= cfg_data;
                default:               cfg_reg               <= cfg_reg;
            endcase
        end
    end

    nsve_ctl u_ctl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (in_byte_reg),
        .cfg    (cfg_reg),
        .emit   (ctl_emit),
        .result (ctl_result)
    );

    // The held byte moves on unless it produces a result and the output
    // register is full and stalled.
    assign advance  = in_full_reg && (!ctl_emit || !out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && ctl_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && ctl_emit)
        begin
            res_reg <= ctl_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = res_reg.status;
    assign kind      = res_reg.kind;
    assign value_a   = $signed(res_reg.value_a);
    assign value_b   = $signed(res_reg.value_b);

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != nsve_pkg::ST_PARSED))
        |-> ((kind == nsve_pkg::KIND_NONE) && (value_a == 32'sd0) && (value_b == 32'sd0)))
        else $error("error result carries a kind or a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != nsve_pkg::KIND_SPEED)) |-> (value_b == 32'sd0))
        else $error("second value set outside a speed sentence");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_full_reg))
        else $error("result raised without a byte in the input register");

endmodule

>>> tb/tb_nmea_sentence_value_extractor_top.sv
`timescale 1ns / 100ps

module tb_nmea_sentence_value_extractor_top;
    import nsve_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 250;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    // Tracks the sentence state byte by byte and keeps the readings that
    // the block owes us, oldest first.
    class sentence_board;
        cfg_t        fields;
        phase_t      stage;
        int unsigned byte_count;
        int unsigned field_idx;
        logic [39:0] sentence_id;
        logic [2:0]  cur_kind;
        bit          beyond;
        logic [31:0] accum_a;
        logic [31:0] accum_b;
        nphase_t     num_stage;
        logic [63:0] num_mag;
        int unsigned frac_cnt;
        bit          negative;
        bit          round_up;
        result_t     pending_readings[$];
        int          errors;
        int          readings_made;

        function new();
            fields.temp_field    = CFG_TEMP_RST;
            fields.depth_field   = CFG_DEPTH_RST;
            fields.speed_field_a = CFG_SPEED_A_RST;
            fields.speed_field_b = CFG_SPEED_B_RST;
            fields.meteo_field   = CFG_METEO_RST;
            stage         = PH_HUNT;
            byte_count    = 0;
            field_idx     = 0;
            sentence_id   = '0;
            cur_kind      = KIND_NONE;
            beyond        = 1'b0;
            accum_a       = '0;
            accum_b       = '0;
            errors        = 0;
            readings_made = 0;
            clear_number();
        endfunction

        function void clear_number();
            num_stage = NP_START;
            num_mag   = '0;
            frac_cnt  = 0;
            negative  = 1'b0;
            round_up  = 1'b0;
        endfunction

        function logic [31:0] number_value();
            logic [63:0] m;
            logic [63:0] sat;
            sat = {32'd0, MAG_SAT};
            m = num_mag + (round_up ? 64'd1 : 64'd0);
            if (negative)
            begin
                if (m > sat)
                    m = sat;
                return 32'd0 - m[31:0];
            end
            if (m > sat - 64'd1)
                m = sat - 64'd1;
            return m[31:0];
        endfunction

        function void feed_number(logic [7:0] c);
            bit          is_digit;
            logic [63:0] d;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            d = {56'd0, c - CH_ZERO};
            if (num_stage == NP_START)
            begin
                // Leading blanks are space and the range from tab to form feed.
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_FF))
                    return;
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    negative  = (c == CH_MINUS);
                    num_stage = NP_SIGNED;
                    return;
                end
            end
            case (num_stage)
                NP_START, NP_SIGNED, NP_INT:
                begin
                    if (is_digit)
                    begin
                        num_mag = num_mag * 10 + 100 * d;
                        if (num_mag > {32'd0, MAG_SAT})
                            num_mag = {32'd0, MAG_SAT};
                        num_stage = NP_INT;
                    end
                    else if (c == CH_DOT)
                        num_stage = NP_FRAC;
                    else
                        num_stage = NP_DONE;
                end
                NP_FRAC:
                begin
                    if (!is_digit)
                        num_stage = NP_DONE;
                    else
                    begin
                        // The third fractional digit only decides the rounding.
                        if (frac_cnt == 0)
                            num_mag = num_mag + 10 * d;
                        else if (frac_cnt == 1)
                            num_mag = num_mag + d;
                        else if (frac_cnt == 2)
                            round_up = (d >= 5);
                        if (num_mag > {32'd0, MAG_SAT})
                            num_mag = {32'd0, MAG_SAT};
                        if (frac_cnt < 3)
                            frac_cnt++;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void close_field();
            logic [4:0]  ta;
            logic [4:0]  tb;
            logic [31:0] v;
            if (beyond)
                return;
            if (field_idx == 0)
            begin
                cur_kind = KIND_NONE;
                if (byte_count == 6)
                begin
                    if (sentence_id == ID_MTW)
                        cur_kind = KIND_TEMP;
                    else if (sentence_id == ID_DPT)
                        cur_kind = KIND_DEPTH;
                    else if (sentence_id == ID_VHW)
                        cur_kind = KIND_SPEED;
                    else if (sentence_id == ID_MDA)
                        cur_kind = KIND_METEO;
                end
                return;
            end
            ta = '0;
            tb = '0;
            v  = number_value();
            case (cur_kind)
                KIND_TEMP:  ta = fields.temp_field;
                KIND_DEPTH: ta = fields.depth_field;
                KIND_SPEED:
                begin
                    ta = fields.speed_field_a;
                    tb = fields.speed_field_b;
                end
                KIND_METEO: ta = fields.meteo_field;
                default:    ;
            endcase
            if (ta != 0 && field_idx == ta)
                accum_a = v;
            if (tb != 0 && field_idx == tb)
                accum_b = v;
        endfunction

        function void owe_reading(logic [1:0] st, logic [2:0] k, logic [31:0] a,
                                  logic [31:0] b);
            result_t r;
            r.status  = st;
            r.kind    = k;
            r.value_a = a;
            r.value_b = b;
            pending_readings.push_back(r);
            readings_made++;
            stage      = PH_HUNT;
            byte_count = 0;
        endfunction

        // Called for every accepted byte transaction.
        function void take_byte(logic [7:0] c);
            if (stage == PH_HUNT)
            begin
                if (c == CH_DOLLAR)
                begin
                    stage       = PH_BODY;
                    byte_count  = 1;
                    field_idx   = 0;
                    sentence_id = '0;
                    cur_kind    = KIND_NONE;
                    beyond      = 1'b0;
                    accum_a     = '0;
                    accum_b     = '0;
                    clear_number();
                end
                return;
            end
            if (stage == PH_LF)
            begin
                if (c != CH_LF)
                    owe_reading(ST_NO_LF, KIND_NONE, '0, '0);
                else if (cur_kind == KIND_NONE)
                    owe_reading(ST_UNKNOWN, KIND_NONE, '0, '0);
                else
                    owe_reading(ST_PARSED, cur_kind, accum_a,
                                (cur_kind == KIND_SPEED) ? accum_b : 32'd0);
                return;
            end
            if (c == CH_CR)
            begin
                close_field();
                stage = PH_LF;
                return;
            end
            if (byte_count + 1 > MAX_SENTENCE)
            begin
                owe_reading(ST_OVERRUN, KIND_NONE, '0, '0);
                return;
            end
            if (c == CH_COMMA)
            begin
                close_field();
                if (field_idx >= MAX_FIELDS - 1)
                    beyond = 1'b1;
                else
                    field_idx++;
                clear_number();
            end
            else if (field_idx == 0)
                sentence_id = {sentence_id[31:0], c};
            else if (!beyond)
                feed_number(c);
            byte_count++;
        endfunction

        function void check_reading(logic [1:0] st, logic [2:0] k, logic [31:0] a,
                                    logic [31:0] b);
            result_t want;
            if (pending_readings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d kind=%0d value_a=%0d value_b=%0d",
                         $time, st, k, $signed(a), $signed(b));
                return;
            end
            want = pending_readings.pop_front();
            if (want.status !== st || want.kind !== k || want.value_a !== a
                || want.value_b !== b)
            begin
                errors++;
                $display("%0t: expected status=%0d kind=%0d value_a=%0d value_b=%0d",
                         $time, want.status, want.kind, $signed(want.value_a),
                         $signed(want.value_b));
                $display("%0t:   actual status=%0d kind=%0d value_a=%0d value_b=%0d",
                         $time, st, k, $signed(a), $signed(b));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [2:0]  kind;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sentence_board board;
    logic [7:0]    tx_q[$];
    bit            calm = 1'b0;
    bit            hold_req = 1'b0;
    int            cycle_count = 0;

    nmea_sentence_value_extractor_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .kind      (kind),
        .value_a   (value_a),
        .value_b   (value_b),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on each request, counted here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 22);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_reading(status, kind, value_a, value_b);
    end

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            tx_q.push_back(s[i]);
    endfunction

    function automatic void push_fill(logic [7:0] c, int n);
        repeat (n)
            tx_q.push_back(c);
    endfunction

    function automatic void push_digit();
        tx_q.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void push_number();
        int    r;
        int    n_int;
        string trailers;
        trailers = "*ABCKMNT";
        r = $urandom_range(99);
        if (r < 8)
            tx_q.push_back(CH_SPACE);
        else if (r < 12)
            tx_q.push_back(CH_TAB);
        r = $urandom_range(5);
        if (r < 2)
            tx_q.push_back(CH_MINUS);
        else if (r == 2)
            tx_q.push_back(CH_PLUS);
        // Now and then a long integer part drives the value into saturation.
        n_int = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
        repeat (n_int)
            push_digit();
        if ($urandom_range(9) < 6)
        begin
            tx_q.push_back(CH_DOT);
            repeat ($urandom_range(0, 4))
                push_digit();
        end
        if ($urandom_range(9) < 3)
            tx_q.push_back(trailers[$urandom_range(7)]);
    endfunction

    function automatic void push_field();
        int    r;
        string letters;
        letters = "TMNKCBI";
        r = $urandom_range(99);
        if (r < 70)
            push_number();
        else if (r >= 85 && r < 95)
            tx_q.push_back(letters[$urandom_range(6)]);
        else if (r >= 95)
            repeat ($urandom_range(1, 3))
                tx_q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void make_sentence();
        int r;
        int n_fields;
        int start;
        if ($urandom_range(19) == 0)
            repeat ($urandom_range(1, 4))
                tx_q.push_back(8'($urandom_range(255)));
        start = tx_q.size();
        tx_q.push_back(CH_DOLLAR);
        r = $urandom_range(99);
        if (r < 20)
            push_str("GPMTW");
        else if (r < 40)
            push_str("GPDPT");
        else if (r < 60)
            push_str("GPVHW");
        else if (r < 80)
            push_str("GPMDA");
        else if (r < 86)
            push_str("GPXDR");
        else if (r < 90)
            push_str("GPMT");
        else if (r < 94)
            push_str("GPVHWX");
        else
            repeat (5)
                tx_q.push_back(8'h41 + 8'($urandom_range(25)));
        n_fields = ($urandom_range(9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 9);
        repeat (n_fields)
        begin
            tx_q.push_back(CH_COMMA);
            // Long sentences keep their fields short to stay within the length.
            if (n_fields > 20)
            begin
                if ($urandom_range(1) == 0)
                    push_digit();
            end
            else
                push_field();
        end
        r = $urandom_range(99);
        if (r < 86)
        begin
            tx_q.push_back(CH_CR);
            tx_q.push_back(CH_LF);
        end
        else if (r < 94)
        begin
            tx_q.push_back(CH_CR);
            tx_q.push_back(8'($urandom_range(255)));
        end
        else
            while (tx_q.size() - start < 132)
                tx_q.push_back(8'h41 + 8'($urandom_range(25)));
    endfunction

    task automatic send_byte(logic [7:0] b);
        while (!calm && $urandom_range(99) < 22)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_byte(b);
    endtask

    task automatic send_queue();
        foreach (tx_q[i])
            send_byte(tx_q[i]);
        tx_q.delete();
    endtask

    // Drops valid, waits for every owed reading and lets the pipeline settle.
    task automatic wait_quiet();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (board.pending_readings.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (board.pending_readings.size() != 0)
        begin
            board.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     board.pending_readings.size());
            board.pending_readings.delete();
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_fields(cfg_t f);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TEMP;
        cfg_data  <= f.temp_field;
        @(negedge clk);
        cfg_index <= CFG_DEPTH;
        cfg_data  <= f.depth_field;
        @(negedge clk);
        cfg_index <= CFG_SPEED_A;
        cfg_data  <= f.speed_field_a;
        @(negedge clk);
        cfg_index <= CFG_SPEED_B;
        cfg_data  <= f.speed_field_b;
        @(negedge clk);
        cfg_index <= CFG_METEO;
        cfg_data  <= f.meteo_field;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.fields = f;
    endtask

    task automatic run_random(int min_bytes, int min_readings, bit with_hold);
        int sent;
        int made_mark;
        int count;
        sent      = 0;
        count     = 0;
        made_mark = board.readings_made;
        while (sent < min_bytes || board.readings_made - made_mark < min_readings)
        begin
            make_sentence();
            sent += tx_q.size();
            send_queue();
            count++;
            // The sender keeps offering bytes while the receiver holds off.
            if (with_hold && count == 1)
                hold_req = 1'b1;
        end
    endtask

    task automatic run_directed();
        // Bytes outside a sentence are ignored, whatever their value.
        tx_q.push_back(8'h00);
        tx_q.push_back(8'hFF);
        tx_q.push_back(CH_LF);
        tx_q.push_back(CH_CR);
        push_str("G");
        push_str("$GPMTW,12.345,C\r\n");
        push_str("$GPMTW,-0.005,C\r\n");
        push_str("$GPDPT,4.1,-3.335,0.0\r\n");
        push_str("$GPVHW,,T,,M,5.5,N,10.19,K\r\n");
        push_str("$GPMDA,30.1,I,1.02,B,20.5,C,18.25,C\r\n");
        push_str("$GPMTW, \t+7.,C*4A\r\n");
        push_str("$GPMTW,-0\r\n");
        push_str("$GPMTW,-\r\n");
        push_str("$GPMTW,1.999\r\n");
        push_str("$GPMTW,99999999999.99\r\n");
        push_str("$GPMTW,21474836.47\r\n");
        push_str("$GPMTW,-21474836.48\r\n");
        push_str("$GPMTW,-21474837\r\n");
        push_str("$GPXDR,1.5\r\n");
        push_str("$GPMTWX,1\r\n");
        push_str("$GPMT,1\r\n");
        push_str("$GP$MTW,1\r\n");
        push_str("$GPDPT\r\n");
        // A '$' where LF belongs is dropped along with the rest of that line.
        push_str("$GPMTW,1\r$GPMTW,2\r\n");
        push_str("$GPMTW,1");
        tx_q.push_back(8'h00);
        push_str("5\r\n");
        push_str("$GP");
        tx_q.push_back(8'h00);
        push_str("TW,1\r\n");
        push_str("$GPMTW");
        repeat (33)
            push_str(",1");
        push_str("\r\n");
        // Longest sentence that fits, then one byte too long.
        push_str("$GPMTW,");
        push_fill(CH_SPACE, 117);
        push_str("12.5\r\n");
        push_str("$GPMTW,");
        push_fill(CH_SPACE, 118);
        push_str("12.5\r\n");
        send_queue();
    endtask

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4)
            @(posedge clk);

        run_directed();
        wait_quiet();
        run_random(60, 3, 1'b1);
        wait_quiet();

        write_fields({5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)),
                      5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)),
                      5'($urandom_range(1, 6))});
        calm = 1'b1;
        run_random(40, 2, 1'b0);
        wait_quiet();
        calm = 1'b0;

        write_fields({5'd31, 5'd1, 5'd1, 5'd31, 5'd31});
        run_random(40, 2, 1'b0);
        wait_quiet();

        write_fields({5'd0, 5'd31, 5'd31, 5'd0, 5'd1});
        run_random(40, 2, 1'b0);
        wait_quiet();

        write_fields({5'($urandom_range(1, 8)), 5'($urandom_range(1, 8)),
                      5'($urandom_range(1, 8)), 5'($urandom_range(1, 8)),
                      5'($urandom_range(1, 8))});
        run_random(60, 3, 1'b1);
        wait_quiet();

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
